/* rtl/core/compass_template_edge_magnitude_assert.svh */
// Assertion macros used by the checker file of the edge magnitude block.
`ifndef COMPASS_TEMPLATE_EDGE_MAGNITUDE_ASSERT_SVH
`define COMPASS_TEMPLATE_EDGE_MAGNITUDE_ASSERT_SVH

// Checks a condition at every clock edge while out of reset.
`define CEMAG_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CEMAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/cemag_pkg.sv */
// Types and constants of the compass template edge magnitude block.
`timescale 1ns / 1ps
package cemag_pkg;

	localparam int PixW      = 8;
	localparam int GainW     = 16;
	localparam int FracBits  = 8;
	localparam int RingLen   = 8;
	localparam int TripW     = PixW + 2;   // sum of three pixels
	localparam int SumW      = PixW + 3;   // sum of the eight ring pixels
	localparam int RespW     = SumW + 2;   // signed template response
	localparam int BestW     = 11;         // floored response, at most 1275
	localparam int ProdW     = BestW + GainW;
	localparam int ScaledW   = ProdW - FracBits;

	localparam logic [GainW-1:0] GainReset = 16'd512;
	localparam logic [PixW-1:0]  PixMax    = 8'd255;

	typedef logic [PixW-1:0]  pix_t;
	typedef logic [GainW-1:0] gain_t;
	typedef logic [BestW-1:0] best_t;
	typedef logic [TripW-1:0] trip_t;
	typedef pix_t ring_t [RingLen];

endpackage

/* rtl/core/cemag_resp.sv */
// Template response stages: ring triple sums, then the largest response with a floor of 0.
`timescale 1ns / 1ps
module cemag_resp
	import cemag_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_in,
	input  ring_t ring,
	input  pix_t  center,
	output logic  valid_out,
	output best_t best
);

	// Every template weights five consecutive ring pixels plus and three minus, so
	// response = ring sum - 2 * center - 2 * (sum of the three minus pixels).
	// The largest response therefore comes from the smallest consecutive triple.
	trip_t                   trip_d [RingLen];
	trip_t                   trip_s2 [RingLen];
	logic signed [RespW-1:0] base_d;
	logic signed [RespW-1:0] base_s2;
	logic                    valid_s2;
	logic                    valid_s3;
	best_t                   best_s3;
	logic [SumW-1:0]         ring_sum;
	trip_t                   trip_min;
	logic signed [RespW-1:0] resp;

	for (genvar k = 0; k < RingLen; k++) begin : g_trip
		localparam int K1 = (k + 1) % RingLen;
		localparam int K2 = (k + 2) % RingLen;
		assign trip_d[k] = {2'b00, ring[k]} + {2'b00, ring[K1]} + {2'b00, ring[K2]};
	end

	always_comb begin
		ring_sum = '0;
		for (int k = 0; k < RingLen; k++) begin
			ring_sum = ring_sum + {3'b000, ring[k]};
		end
		base_d = $signed({2'b00, ring_sum}) - $signed({(RespW-PixW-1)'(0), center, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		trip_s2 <= trip_d;
		base_s2 <= base_d;
	end

	always_comb begin
		trip_min = trip_s2[0];
		for (int k = 1; k < RingLen; k++) begin
			if (trip_s2[k] < trip_min) begin
				trip_min = trip_s2[k];
			end
		end
		resp = base_s2 - $signed({2'b00, trip_min, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		best_s3 <= resp[RespW-1] ? '0 : resp[BestW-1:0];
	end

	assign valid_out = valid_s3;
	assign best      = best_s3;

endmodule

/* rtl/core/cemag_scale.sv */
// Gain stage: multiplies the largest response by the 8.8 gain, truncates and saturates.
`timescale 1ns / 1ps
module cemag_scale
	import cemag_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_in,
	input  best_t best,
	input  gain_t gain,
	output logic  done,
	output pix_t  pixel
);

	logic [ProdW-1:0]   prod;
	logic [ScaledW-1:0] scaled;
	logic               done_q;
	pix_t               pixel_q;

	assign prod   = {{GainW{1'b0}}, best} * {{BestW{1'b0}}, gain};
	assign scaled = prod[ProdW-1:FracBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (scaled > {{(ScaledW-PixW){1'b0}}, PixMax}) begin
			pixel_q <= PixMax;
		end else begin
			pixel_q <= scaled[PixW-1:0];
		end
	end

	assign done  = done_q;
	assign pixel = pixel_q;

endmodule

/* rtl/core/compass_template_edge_magnitude.sv */
// Top level of the compass template edge magnitude block.
`timescale 1ns / 1ps
// The block takes one 3x3 window per clock whenever start is high; busy is always
// low, so every window is accepted. Each window yields one edge_pixel, shown with
// done high for exactly one cycle once the window has passed four registers: an
// input register loaded at the accepting edge, a register after the ring triple
// sums, a register after the smallest-triple search and response floor, and the
// result register after the gain multiply. The receiver cannot stall the block and
// must take each result in the cycle it appears. The gain register resets to 2.0
// and may be rewritten with gain_we only while no window is in flight.
module compass_template_edge_magnitude
	import cemag_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  top_left,
	input  logic [7:0]  top_mid,
	input  logic [7:0]  top_right,
	input  logic [7:0]  mid_left,
	input  logic [7:0]  center,
	input  logic [7:0]  mid_right,
	input  logic [7:0]  bottom_left,
	input  logic [7:0]  bottom_mid,
	input  logic [7:0]  bottom_right,
	input  logic        gain_we,
	input  logic [15:0] gain_wdata,
	output logic        done,
	output logic [7:0]  edge_pixel
);

	gain_t gain_q;
	logic  valid_s1;
	ring_t ring_s1;
	pix_t  center_s1;
	logic  resp_valid;
	best_t resp_best;
	logic  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
		end else if (gain_we) begin
			gain_q <= gain_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// The ring runs clockwise from the top-left corner.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_s1[0] <= top_left;
			ring_s1[1] <= top_mid;
			ring_s1[2] <= top_right;
			ring_s1[3] <= mid_right;
			ring_s1[4] <= bottom_right;
			ring_s1[5] <= bottom_mid;
			ring_s1[6] <= bottom_left;
			ring_s1[7] <= mid_left;
			center_s1  <= center;
		end
	end

	cemag_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.ring      (ring_s1),
		.center    (center_s1),
		.valid_out (resp_valid),
		.best      (resp_best)
	);

	cemag_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (resp_valid),
		.best     (resp_best),
		.gain     (gain_q),
		.done     (done),
		.pixel    (edge_pixel)
	);

endmodule

/* rtl/core/cemag_checker.sv */
// Port-level checker of the edge magnitude block and its bind to the top level.
`timescale 1ns / 1ps
`include "compass_template_edge_magnitude_assert.svh"
module cemag_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [7:0]  top_left,
	input logic [7:0]  top_mid,
	input logic [7:0]  top_right,
	input logic [7:0]  mid_left,
	input logic [7:0]  center,
	input logic [7:0]  mid_right,
	input logic [7:0]  bottom_left,
	input logic [7:0]  bottom_mid,
	input logic [7:0]  bottom_right,
	input logic        done,
	input logic [7:0]  edge_pixel
);

	logic accept;
	logic flat;

	assign accept = start && !busy;
	// A flat window gives a zero response in every template.
	assign flat = (top_left == center) && (top_mid == center) && (top_right == center) &&
		(mid_left == center) && (mid_right == center) && (bottom_left == center) &&
		(bottom_mid == center) && (bottom_right == center);

	`CEMAG_ASSERT_NEXT(a_result_follows, accept, ##3 done, "accepted transaction gave no result")
	`CEMAG_ASSERT_NOW(a_result_has_source, !done || $past(accept, 4), "result without transaction")
	`CEMAG_ASSERT_NEXT(a_flat_is_zero, accept && flat, ##3 (edge_pixel == 8'd0), "flat window not 0")

endmodule

bind compass_template_edge_magnitude cemag_checker u_cemag_checker (.*);
